@@ design/rhp_pkg.sv @@
// Shared types, constants and a helper function for the RTP header parser.
package rhp_pkg;

   localparam int INDEX_W  = 17;
   localparam int TARGET_W = 19;
   localparam int BASE_W   = 7;

   localparam logic [1:0]          RTP_VERSION        = 2'd2;
   localparam logic [BASE_W-1:0]   FIXED_HEADER_BYTES = 7'd12;
   localparam logic [BASE_W-1:0]   EXT_HEADER_BYTES   = 7'd4;
   localparam logic [INDEX_W-1:0]  EXT_WORD_HI_OFFSET = 17'd2;
   localparam logic [INDEX_W-1:0]  EXT_WORD_LO_OFFSET = 17'd3;

   typedef struct packed {
      logic [INDEX_W-1:0]  size;
      logic [15:0]         first_two;
      logic [15:0]         sequence_number;
      logic [31:0]         timestamp;
      logic [31:0]         source_id;
      logic [TARGET_W-1:0] header_target;
   } summary_type;

   function automatic logic [BASE_W-1:0] header_base(input logic [3:0] cc_bits);
      header_base = FIXED_HEADER_BYTES + {1'b0, cc_bits, 2'b00};
   endfunction

endpackage

@@ design/rhp_front.sv @@
// Byte-level front end: captures header fields and emits one summary per packet.
module rhp_front #(
   parameter int MAX_PACKET_BYTES = 65535
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_last_byte,
   output logic                 push_valid,
   input  logic                 push_ready,
   output rhp_pkg::summary_type push_data
);

   logic [rhp_pkg::INDEX_W-1:0]  byte_index_ff, byte_index_in, index_inc;
   logic [15:0]                  first_two_ff, first_two_in;
   logic [15:0]                  sequence_ff, sequence_in;
   logic [31:0]                  timestamp_ff, timestamp_in;
   logic [31:0]                  source_ff, source_in;
   logic [15:0]                  ext_words_ff, ext_words_in;
   logic [rhp_pkg::TARGET_W-1:0] target_ff, target_in;
   logic [rhp_pkg::BASE_W-1:0]   base;
   logic [rhp_pkg::INDEX_W-1:0]  base_wide;
   logic                         has_ext;
   logic                         accept;

   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;
   assign base      = rhp_pkg::header_base(first_two_ff[11:8]);
   assign base_wide = {{(rhp_pkg::INDEX_W-rhp_pkg::BASE_W){1'b0}}, base};
   assign has_ext   = first_two_ff[12];
   assign index_inc = (byte_index_ff <= rhp_pkg::INDEX_W'(MAX_PACKET_BYTES)) ?
                      byte_index_ff + 1'b1 : byte_index_ff;

   always_comb begin
      first_two_in  = first_two_ff;
      sequence_in   = sequence_ff;
      timestamp_in  = timestamp_ff;
      source_in     = source_ff;
      ext_words_in  = ext_words_ff;
      target_in     = target_ff;
      if (byte_index_ff == 17'd0) begin
         first_two_in = {req_data_byte, 8'h00};
         target_in    = rhp_pkg::TARGET_W'(rhp_pkg::header_base(req_data_byte[3:0]));
      end else if (byte_index_ff == 17'd1) begin
         first_two_in = {first_two_ff[15:8], req_data_byte};
      end else if (byte_index_ff < 17'd4) begin
         sequence_in = {sequence_ff[7:0], req_data_byte};
      end else if (byte_index_ff < 17'd8) begin
         timestamp_in = {timestamp_ff[23:0], req_data_byte};
      end else if (byte_index_ff < 17'd12) begin
         source_in = {source_ff[23:0], req_data_byte};
      end else if (has_ext && byte_index_ff == base_wide + rhp_pkg::EXT_WORD_HI_OFFSET) begin
         ext_words_in = {req_data_byte, 8'h00};
      end else if (has_ext && byte_index_ff == base_wide + rhp_pkg::EXT_WORD_LO_OFFSET) begin
         ext_words_in = {ext_words_ff[15:8], req_data_byte};
         target_in    = rhp_pkg::TARGET_W'(base)
                      + rhp_pkg::TARGET_W'(rhp_pkg::EXT_HEADER_BYTES)
                      + {1'b0, ext_words_ff[15:8], req_data_byte, 2'b00};
      end
      byte_index_in = req_last_byte ? '0 : index_inc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= '0;
      end else if (accept) begin
         byte_index_ff <= byte_index_in;
      end
      if (accept) begin
         first_two_ff <= first_two_in;
         sequence_ff  <= sequence_in;
         timestamp_ff <= timestamp_in;
         source_ff    <= source_in;
         ext_words_ff <= ext_words_in;
         target_ff    <= target_in;
      end
   end

   assign push_valid                = accept && req_last_byte;
   assign push_data.size            = index_inc;
   assign push_data.first_two       = first_two_in;
   assign push_data.sequence_number = sequence_in;
   assign push_data.timestamp       = timestamp_in;
   assign push_data.source_id       = source_in;
   assign push_data.header_target   = target_in;

endmodule

@@ design/rhp_queue.sv @@
// Two-entry queue of packet summaries between front end and back end.
module rhp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  rhp_pkg::summary_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output rhp_pkg::summary_type out_data
);

   logic [1:0]           count_ff;
   rhp_pkg::summary_type head_ff, tail_ff;
   logic                 push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = head_ff;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         case (count_ff)
            2'd0: if (push) count_ff <= 2'd1;
            2'd1: begin
               if (push && !pop) count_ff <= 2'd2;
               else if (pop && !push) count_ff <= 2'd0;
            end
            default: if (pop) count_ff <= 2'd1;
         endcase
      end
      case (count_ff)
         2'd0: if (push) head_ff <= in_data;
         2'd1: begin
            if (push && pop) head_ff <= in_data;
            else if (push) tail_ff <= in_data;
         end
         default: if (pop) head_ff <= tail_ff;
      endcase
   end

endmodule

@@ design/rhp_back.sv @@
// Back end: checks a packet summary and holds the result item for the consumer.
module rhp_back #(
   parameter int MAX_PACKET_BYTES = 65535
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  rhp_pkg::summary_type pop_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_valid_res,
   output logic [6:0]           rsp_payload_type,
   output logic                 rsp_marker,
   output logic [15:0]          rsp_sequence_number,
   output logic [31:0]          rsp_timestamp,
   output logic [31:0]          rsp_source_id,
   output logic [15:0]          rsp_header_length,
   output logic [15:0]          rsp_payload_length
);

   logic                         rsp_valid_ff;
   logic                         ok_ff, ok_in;
   logic [6:0]                   type_ff;
   logic                         marker_ff;
   logic [15:0]                  seq_ff;
   logic [31:0]                  ts_ff, ssrc_ff;
   logic [15:0]                  hlen_ff, plen_ff;
   logic [rhp_pkg::INDEX_W-1:0]  base_wide, size;
   logic [rhp_pkg::TARGET_W-1:0] size_wide, diff;
   logic                         has_ext;

   assign size      = pop_data.size;
   assign size_wide = {{(rhp_pkg::TARGET_W-rhp_pkg::INDEX_W){1'b0}}, size};
   assign base_wide = rhp_pkg::INDEX_W'(rhp_pkg::header_base(pop_data.first_two[11:8]));
   assign has_ext   = pop_data.first_two[12];
   assign diff      = size_wide - pop_data.header_target;

   always_comb begin
      ok_in = (size <= rhp_pkg::INDEX_W'(MAX_PACKET_BYTES))
           && (size >= rhp_pkg::INDEX_W'(rhp_pkg::FIXED_HEADER_BYTES))
           && (pop_data.first_two[15:14] == rhp_pkg::RTP_VERSION);
      if (size < base_wide) begin
         ok_in = 1'b0;
      end else if (has_ext && ((size < base_wide + rhp_pkg::INDEX_W'(rhp_pkg::EXT_HEADER_BYTES))
                               || (size_wide < pop_data.header_target))) begin
         ok_in = 1'b0;
      end
   end

   assign pop_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop_ready) begin
         rsp_valid_ff <= pop_valid;
      end
      if (pop_valid && pop_ready) begin
         ok_ff     <= ok_in;
         type_ff   <= ok_in ? pop_data.first_two[6:0] : 7'd0;
         marker_ff <= ok_in && pop_data.first_two[7];
         seq_ff    <= ok_in ? pop_data.sequence_number : 16'd0;
         ts_ff     <= ok_in ? pop_data.timestamp : 32'd0;
         ssrc_ff   <= ok_in ? pop_data.source_id : 32'd0;
         hlen_ff   <= ok_in ? pop_data.header_target[15:0] : 16'd0;
         plen_ff   <= ok_in ? diff[15:0] : 16'd0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_valid_res       = ok_ff;
   assign rsp_payload_type    = type_ff;
   assign rsp_marker          = marker_ff;
   assign rsp_sequence_number = seq_ff;
   assign rsp_timestamp       = ts_ff;
   assign rsp_source_id       = ssrc_ff;
   assign rsp_header_length   = hlen_ff;
   assign rsp_payload_length  = plen_ff;

endmodule

@@ design/rtp_header_parser.sv @@
// Top level of the RTP header parser: front end, summary queue, back end.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid / req_ready  data_byte, last_byte
//   rsp_     out        rsp_valid / rsp_ready  one result item per packet
//
// One byte item per clock is taken while req_ready is high; header fields are
// captured as they pass. The last byte of a packet pushes a summary into a
// two-entry queue at the edge that takes it; the back end pops it, checks it
// and registers the result item in its output register for the consumer.
// Reset clears the byte count, the queue and the output valid.
// req_ready drops only when the queue is full; a stalled rsp_ side backs up
// through the queue, and once it is full the input stalls, also in mid-packet.
module rtp_header_parser #(
   parameter int MAX_PACKET_BYTES = 65535
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_valid_res,
   output logic [6:0]  rsp_payload_type,
   output logic        rsp_marker,
   output logic [15:0] rsp_sequence_number,
   output logic [31:0] rsp_timestamp,
   output logic [31:0] rsp_source_id,
   output logic [15:0] rsp_header_length,
   output logic [15:0] rsp_payload_length
);

   logic                 push_valid, push_ready;
   rhp_pkg::summary_type push_data;
   logic                 pop_valid, pop_ready;
   rhp_pkg::summary_type pop_data;

   rhp_front #(.MAX_PACKET_BYTES(MAX_PACKET_BYTES)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_data     (push_data)
   );

   rhp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_data  (pop_data)
   );

   rhp_back #(.MAX_PACKET_BYTES(MAX_PACKET_BYTES)) u_back (
      .clock               (clock),
      .reset               (reset),
      .pop_valid           (pop_valid),
      .pop_ready           (pop_ready),
      .pop_data            (pop_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_valid_res       (rsp_valid_res),
      .rsp_payload_type    (rsp_payload_type),
      .rsp_marker          (rsp_marker),
      .rsp_sequence_number (rsp_sequence_number),
      .rsp_timestamp       (rsp_timestamp),
      .rsp_source_id       (rsp_source_id),
      .rsp_header_length   (rsp_header_length),
      .rsp_payload_length  (rsp_payload_length)
   );

   a_push_on_last: assert property (@(posedge clock) disable iff (reset)
      push_valid == (req_valid && req_ready && req_last_byte))
      else $error("summary push does not match last-byte accept");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_valid_res) |-> (rsp_payload_type == 7'd0 && !rsp_marker
         && rsp_sequence_number == 16'd0 && rsp_timestamp == 32'd0
         && rsp_source_id == 32'd0 && rsp_header_length == 16'd0
         && rsp_payload_length == 16'd0))
      else $error("invalid packet result carries nonzero fields");

   a_header_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_valid_res) |-> (rsp_header_length >= 16'd12
         && rsp_header_length[1:0] == 2'b00))
      else $error("valid packet has malformed header length");

   a_ready_drop: assert property (@(posedge clock) disable iff (reset)
      (!req_ready) |-> (pop_valid && !push_ready))
      else $error("input stalled while queue not full");

endmodule
